// File: rtl/ppg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPG heart-rate package
// Shared widths, reset values, register indexes, status codes and the types
// that pass between the sample tracker, the divider and the sequencer.
// ----------------------------------------------------------------------------
package ppg_pkg;

    // Field widths.
    localparam int SAMPLE_W = 18;
    localparam int GAP_W    = 10;
    localparam int PEAKS_W  = 8;
    localparam int RATE_W   = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Widest peak position carried between modules (MAX_SAMPLES up to 65536).
    localparam int POS_W = 16;

    // Divider width and its step counter.
    localparam int DIV_W     = 16;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam int MAX_SAMPLES_DEF = 1024;

    // Register reset values.
    localparam logic [SAMPLE_W-1:0] CREST_LEVEL_RST    = 18'd500;
    localparam logic [GAP_W-1:0]    MIN_PEAK_GAP_RST   = 10'd30;
    localparam logic [PEAKS_W-1:0]  MAX_PEAKS_RST      = 8'd50;
    localparam logic [RATE_W-1:0]   RATE_SCALE_RST     = 16'd6000;
    localparam logic [RATE_W-1:0]   RATE_MIN_RST       = 16'd30;
    localparam logic [RATE_W-1:0]   RATE_MAX_RST       = 16'd250;
    localparam logic [SAMPLE_W-1:0] MIN_SWING_RST      = 18'd2000;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CREST_LEVEL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PEAK_GAP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PEAKS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_MIN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_MAX       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SWING      = 3'd6;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_WEAK      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FEW_PEAKS = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE     = 4'b0001,
        S_EVAL     = 4'b0010,
        S_DIV_MEAN = 4'b0100,
        S_DIV_RATE = 4'b1000
    } seq_state_t;

    typedef struct packed {
        logic [PEAKS_W-1:0]  peak_total;
        logic [POS_W-1:0]    first_pos;
        logic [POS_W-1:0]    last_pos;
        logic [SAMPLE_W-1:0] run_max;
        logic [SAMPLE_W-1:0] run_min;
    } run_info_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: rtl/ppg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPG shared divider
// Restoring unsigned divider, one quotient bit per cycle, done strobe at end.
// ----------------------------------------------------------------------------
module ppg_div (
    input  logic               clk,
    input  logic               rst_n,
    input  ppg_pkg::div_req_t  req,
    output ppg_pkg::div_rsp_t  rsp
);

    logic [ppg_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [ppg_pkg::DIV_CNT_W-1:0] cnt_next;
    logic                          done_reg;
    logic                          done_next;
    logic [ppg_pkg::DIV_W-1:0]     rem_reg;
    logic [ppg_pkg::DIV_W-1:0]     rem_next;
    logic [ppg_pkg::DIV_W-1:0]     quo_reg;
    logic [ppg_pkg::DIV_W-1:0]     quo_next;
    logic [ppg_pkg::DIV_W-1:0]     dsr_reg;
    logic [ppg_pkg::DIV_W:0]       rem_shift;
    logic                          active;

    assign active    = (cnt_reg != '0);
    assign rem_shift = {rem_reg, quo_reg[ppg_pkg::DIV_W-1]};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            cnt_next = ppg_pkg::DIV_CNT_W'(ppg_pkg::DIV_W);
            rem_next = '0;
            quo_next = req.dividend;
        end
        else if (active)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == ppg_pkg::DIV_CNT_W'(1));
            if (rem_shift >= {1'b0, dsr_reg})
            begin
                rem_next = ppg_pkg::DIV_W'(rem_shift - {1'b0, dsr_reg});
                quo_next = {quo_reg[ppg_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[ppg_pkg::DIV_W-1:0];
                quo_next = {quo_reg[ppg_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (req.start)
        begin
            dsr_reg <= req.divisor;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: rtl/ppg_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPG sample tracker
// Keeps the sample window, run extremes and accepted peak positions.
// ----------------------------------------------------------------------------
module ppg_track #(
    parameter int MAX_SAMPLES = ppg_pkg::MAX_SAMPLES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic [ppg_pkg::SAMPLE_W-1:0]  sample,
    input  logic                          clear,
    input  logic [ppg_pkg::SAMPLE_W-1:0]  crest_level,
    input  logic [ppg_pkg::GAP_W-1:0]     min_peak_gap,
    input  logic [ppg_pkg::PEAKS_W-1:0]   max_peaks,
    output ppg_pkg::run_info_t            info
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int PW = $clog2(MAX_SAMPLES);
    localparam int GW = (PW > ppg_pkg::GAP_W) ? PW : ppg_pkg::GAP_W;

    logic [ppg_pkg::SAMPLE_W-1:0] win_reg [4];
    logic [CW-1:0]                pos_reg;
    logic [ppg_pkg::PEAKS_W-1:0]  total_reg;
    logic [ppg_pkg::PEAKS_W-1:0]  total_next;
    logic [PW-1:0]                first_reg;
    logic [PW-1:0]                last_reg;
    logic [ppg_pkg::SAMPLE_W-1:0] max_reg;
    logic [ppg_pkg::SAMPLE_W-1:0] min_reg;
    logic                         stop_reg;

    logic                         keep;
    logic [PW-1:0]                cpos;
    logic [PW-1:0]                span;
    logic                         is_peak;
    logic                         gap_ok;
    logic                         accept_peak;

    // Samples past the storage limit are dropped but still end a run.
    assign keep = take && (pos_reg != CW'(MAX_SAMPLES));
    assign cpos = PW'(pos_reg - CW'(2));
    assign span = cpos - last_reg;

    assign is_peak = (pos_reg >= CW'(4)) && !stop_reg
                     && (win_reg[1] > crest_level)
                     && (win_reg[1] > win_reg[0]) && (win_reg[1] > win_reg[2])
                     && (win_reg[1] > win_reg[3]) && (win_reg[1] > sample);
    assign gap_ok = (total_reg == '0) || (GW'(span) > GW'(min_peak_gap));
    assign accept_peak = keep && is_peak && gap_ok;
    assign total_next  = total_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                win_reg[i] <= '0;
            end
            pos_reg   <= '0;
            total_reg <= '0;
            first_reg <= '0;
            last_reg  <= '0;
            max_reg   <= '0;
            min_reg   <= '1;
            stop_reg  <= 1'b0;
        end
        else if (clear)
        begin
            for (int i = 0; i < 4; i++)
            begin
                win_reg[i] <= '0;
            end
            pos_reg   <= '0;
            total_reg <= '0;
            first_reg <= '0;
            last_reg  <= '0;
            max_reg   <= '0;
            min_reg   <= '1;
            stop_reg  <= 1'b0;
        end
        else if (keep)
        begin
            win_reg[0] <= sample;
            win_reg[1] <= win_reg[0];
            win_reg[2] <= win_reg[1];
            win_reg[3] <= win_reg[2];
            pos_reg    <= pos_reg + 1'b1;
            if (sample > max_reg)
            begin
                max_reg <= sample;
            end
            if (sample < min_reg)
            begin
                min_reg <= sample;
            end
            if (accept_peak)
            begin
                if (total_reg == '0)
                begin
                    first_reg <= cpos;
                end
                last_reg  <= cpos;
                total_reg <= total_next;
                if (total_next >= max_peaks)
                begin
                    stop_reg <= 1'b1;
                end
            end
        end
    end

    assign info.peak_total = total_reg;
    assign info.first_pos  = ppg_pkg::POS_W'(first_reg);
    assign info.last_pos   = ppg_pkg::POS_W'(last_reg);
    assign info.run_max    = max_reg;
    assign info.run_min    = min_reg;

endmodule

// File: rtl/ppg_peak_heart_rate_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPG peak detector and heart-rate unit
// Finds pulse peaks in a run of infrared samples and reports the heart rate.
// ----------------------------------------------------------------------------
// Usage: a sample beat is taken at a rising edge with start high and busy low.
// An ordinary sample is absorbed without stalling, so samples can stream at
// one per clock and busy stays low. A sample with last set closes the run:
// busy rises for the evaluation, which uses one shared 16-bit restoring
// divider up to twice (mean peak interval, then rate), one quotient bit per
// cycle. The result beat appears for exactly one cycle on done together with
// heart_rate, status and peaks_found. It comes straight from evaluation for a
// weak signal or too few peaks, after the first division for a zero mean interval
// and after the second for a full rate. The receiver cannot stall the result;
// it must take it in the cycle where done is high. Configuration is written
// through cfg_we, cfg_index and cfg_data; the user must write it only while
// the unit is idle, which the block itself does not enforce. Reset loads the
// register defaults and clears the run state; a finished run clears it too.
// ----------------------------------------------------------------------------
module ppg_peak_heart_rate_unit #(
    parameter int MAX_SAMPLES = ppg_pkg::MAX_SAMPLES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ppg_pkg::SAMPLE_W-1:0]    sample,
    input  logic                            last,
    output logic                            done,
    output logic [ppg_pkg::RATE_W-1:0]      heart_rate,
    output logic [ppg_pkg::STATUS_W-1:0]    status,
    output logic [ppg_pkg::PEAKS_W-1:0]     peaks_found,
    input  logic                            cfg_we,
    input  logic [ppg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ppg_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers.
    logic [ppg_pkg::SAMPLE_W-1:0] crest_level_reg;
    logic [ppg_pkg::GAP_W-1:0]    min_peak_gap_reg;
    logic [ppg_pkg::PEAKS_W-1:0]  max_peaks_reg;
    logic [ppg_pkg::RATE_W-1:0]   rate_scale_reg;
    logic [ppg_pkg::RATE_W-1:0]   rate_min_reg;
    logic [ppg_pkg::RATE_W-1:0]   rate_max_reg;
    logic [ppg_pkg::SAMPLE_W-1:0] min_swing_reg;

    ppg_pkg::seq_state_t state_reg;
    ppg_pkg::seq_state_t state_next;

    logic                         done_reg;
    logic                         done_next;
    logic [ppg_pkg::RATE_W-1:0]   rate_reg;
    logic [ppg_pkg::RATE_W-1:0]   rate_next;
    logic [ppg_pkg::STATUS_W-1:0] status_reg;
    logic [ppg_pkg::STATUS_W-1:0] status_next;
    logic [ppg_pkg::PEAKS_W-1:0]  peaks_reg;
    logic [ppg_pkg::PEAKS_W-1:0]  peaks_next;

    logic                 accept;
    logic                 clear_run;
    logic                 swing_low;
    ppg_pkg::run_info_t   info;
    ppg_pkg::div_req_t    div_req;
    ppg_pkg::div_rsp_t    div_rsp;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crest_level_reg    <= ppg_pkg::CREST_LEVEL_RST;
            min_peak_gap_reg   <= ppg_pkg::MIN_PEAK_GAP_RST;
            max_peaks_reg      <= ppg_pkg::MAX_PEAKS_RST;
            rate_scale_reg     <= ppg_pkg::RATE_SCALE_RST;
            rate_min_reg       <= ppg_pkg::RATE_MIN_RST;
            rate_max_reg       <= ppg_pkg::RATE_MAX_RST;
            min_swing_reg      <= ppg_pkg::MIN_SWING_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ppg_pkg::REG_CREST_LEVEL:    crest_level_reg    <= cfg_data;
                ppg_pkg::REG_MIN_PEAK_GAP:   min_peak_gap_reg   <= cfg_data[ppg_pkg::GAP_W-1:0];
                ppg_pkg::REG_MAX_PEAKS:      max_peaks_reg      <= cfg_data[ppg_pkg::PEAKS_W-1:0];
                ppg_pkg::REG_RATE_SCALE:     rate_scale_reg     <= cfg_data[ppg_pkg::RATE_W-1:0];
                ppg_pkg::REG_RATE_MIN:       rate_min_reg       <= cfg_data[ppg_pkg::RATE_W-1:0];
                ppg_pkg::REG_RATE_MAX:       rate_max_reg       <= cfg_data[ppg_pkg::RATE_W-1:0];
                ppg_pkg::REG_MIN_SWING:      min_swing_reg      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    ppg_track #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (accept),
        .sample       (sample),
        .clear        (clear_run),
        .crest_level  (crest_level_reg),
        .min_peak_gap (min_peak_gap_reg),
        .max_peaks    (max_peaks_reg),
        .info         (info)
    );

    ppg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // A run with no kept sample has its minimum above its maximum; its swing
    // then counts as zero.
    assign swing_low = (info.run_max >= info.run_min)
                       ? ((info.run_max - info.run_min) < min_swing_reg)
                       : (min_swing_reg != '0);

    // Sequencer: evaluation of the closed run, with the divider used first for
    // the mean peak interval and then for the rate. Every finishing branch
    // loads the result registers, pulses done and clears the run.
    always_comb
    begin
        state_next       = state_reg;
        done_next        = 1'b0;
        rate_next        = rate_reg;
        status_next      = status_reg;
        peaks_next       = peaks_reg;
        clear_run        = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = ppg_pkg::DIV_W'(info.last_pos - info.first_pos);
        div_req.divisor  = ppg_pkg::DIV_W'(info.peak_total - 1'b1);
        unique case (state_reg)
            ppg_pkg::S_IDLE:
            begin
                if (accept && last)
                begin
                    state_next = ppg_pkg::S_EVAL;
                end
            end
            ppg_pkg::S_EVAL:
            begin
                peaks_next = info.peak_total;
                rate_next  = '0;
                if (swing_low)
                begin
                    status_next = ppg_pkg::STATUS_WEAK;
                    done_next   = 1'b1;
                    clear_run   = 1'b1;
                    state_next  = ppg_pkg::S_IDLE;
                end
                else if (info.peak_total < ppg_pkg::PEAKS_W'(2))
                begin
                    status_next = ppg_pkg::STATUS_FEW_PEAKS;
                    done_next   = 1'b1;
                    clear_run   = 1'b1;
                    state_next  = ppg_pkg::S_IDLE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ppg_pkg::S_DIV_MEAN;
                end
            end
            ppg_pkg::S_DIV_MEAN:
            begin
                div_req.dividend = rate_scale_reg;
                div_req.divisor  = div_rsp.quotient;
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient == '0)
                    begin
                        status_next = ppg_pkg::STATUS_RANGE;
                        done_next   = 1'b1;
                        clear_run   = 1'b1;
                        state_next  = ppg_pkg::S_IDLE;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = ppg_pkg::S_DIV_RATE;
                    end
                end
            end
            ppg_pkg::S_DIV_RATE:
            begin
                if (div_rsp.done)
                begin
                    if ((div_rsp.quotient < rate_min_reg) || (div_rsp.quotient > rate_max_reg))
                    begin
                        rate_next   = '0;
                        status_next = ppg_pkg::STATUS_RANGE;
                    end
                    else
                    begin
                        rate_next   = div_rsp.quotient;
                        status_next = ppg_pkg::STATUS_OK;
                    end
                    done_next  = 1'b1;
                    clear_run  = 1'b1;
                    state_next = ppg_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ppg_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppg_pkg::S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rate_reg   <= rate_next;
        status_reg <= status_next;
        peaks_reg  <= peaks_next;
    end

    assign busy        = (state_reg != ppg_pkg::S_IDLE);
    assign done        = done_reg;
    assign heart_rate  = rate_reg;
    assign status      = status_reg;
    assign peaks_found = peaks_reg;

    // A result beat always closes an evaluation.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result beat without a preceding evaluation");

    // A closing sample starts an evaluation in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (accept && last) |=> busy)
        else $error("last sample did not start an evaluation");

    // An ordinary sample is absorbed without stalling and gives no result.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (accept && !last) |=> (!busy && !done))
        else $error("ordinary sample stalled the unit or gave a result");

    // A good rate lies inside the configured range.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (done && (status == ppg_pkg::STATUS_OK))
                     |-> ((heart_rate >= rate_min_reg) && (heart_rate <= rate_max_reg)))
        else $error("reported rate outside the configured range");

    // Any failure status reports a zero rate.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (done && (status != ppg_pkg::STATUS_OK)) |-> (heart_rate == '0))
        else $error("nonzero rate with a failure status");

endmodule
